FILE: sv/assert_macros.svh
// Assertion macros for the RTL files.
// Each macro expands to one labeled concurrent assertion on the rising edge of clk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while rst is low.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked at every edge, also during reset.
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: sv/dsrq_pkg.sv
`default_nettype none

package dsrq_pkg;

  // Indexes of the configuration registers.
  typedef enum logic [2:0] {
    CFG_A_DEBOUNCE = 3'd0,
    CFG_A_STUCK    = 3'd1,
    CFG_A_DELAY    = 3'd2,
    CFG_A_MODE     = 3'd3,
    CFG_B_DEBOUNCE = 3'd4,
    CFG_B_STUCK    = 3'd5,
    CFG_B_DELAY    = 3'd6,
    CFG_B_MODE     = 3'd7
  } cfg_reg_t;

  localparam int unsigned CfgIndexWidth = 3;
  localparam int unsigned CfgDataWidth  = 32;
  localparam int unsigned TimeWidth     = 32;

  // Reset values of the configuration registers.
  localparam logic [TimeWidth-1:0] DebounceReset = 32'd50;
  localparam logic [TimeWidth-1:0] StuckReset    = 32'd30000;
  localparam logic [TimeWidth-1:0] DelayReset    = 32'd1000;

  // Action codes of an input item.
  localparam logic ActStart  = 1'b0;
  localparam logic ActUpdate = 1'b1;

  typedef logic [TimeWidth-1:0] ms_t;

  // One input item.
  typedef struct packed {
    logic action;
    logic a_level;
    logic b_level;
    ms_t  now_ms;
    logic setup_ok;
    logic no_fault;
    logic voltage_ok;
    logic current_ok;
    logic thermal_ok;
  } sample_t;

  // One result item.
  typedef struct packed {
    logic a_request;
    logic b_request;
    logic a_chan1;
    logic a_chan2;
    logic b_chan1;
    logic b_chan2;
    logic a_stuck;
    logic b_stuck;
  } result_t;

  // Settings of one switch pair.
  typedef struct packed {
    ms_t  settle_ms;
    ms_t  hold_limit_ms;
    ms_t  chan2_delay_ms;
    logic maintained;
  } pair_cfg_t;

  // Debounce and latch state of one switch pair.
  typedef struct packed {
    logic raw_pressed;
    logic stable_pressed;
    logic armed;
    logic request_latch;
    logic stuck_flag;
    ms_t  sample_change_time;
    ms_t  press_time;
    ms_t  enable_time;
  } pair_state_t;

  // Next state and channel drives of one pair after one update step.
  typedef struct packed {
    pair_state_t st;
    logic        chan1;
    logic        chan2;
  } pair_step_t;

endpackage

`default_nettype wire

FILE: sv/dual_switch_request_qualifier.sv
// Each sample is registered in the input register, and its result in the result register.
// Throughput: one sample per cycle; the input register and the result register
// are joined by one pass of compare and latch logic, and stall only on result_ready.
// Reset: synchronous, active-high rst empties both registers, clears the started
// flag and all pair state, and loads the configuration registers with their defaults.
`default_nettype none

module dual_switch_request_qualifier (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               sample_valid,
  output logic                                    sample_ready,
  input  wire dsrq_pkg::sample_t                  sample,
  output logic                                    result_valid,
  input  wire logic                               result_ready,
  output dsrq_pkg::result_t                       result,
  input  wire logic                               cfg_write,
  input  wire logic [dsrq_pkg::CfgIndexWidth-1:0] cfg_index,
  input  wire logic [dsrq_pkg::CfgDataWidth-1:0]  cfg_data
);

  import dsrq_pkg::*;

  `include "assert_macros.svh"

  // One update step of a pair. Any timestamp refreshed in this step would give
  // a zero difference, which a valid configuration never reaches, so every
  // compare works from the stored times in parallel.
  function automatic pair_step_t pair_step(pair_state_t s, logic pressed, ms_t now,
                                           logic permit, pair_cfg_t c);
    pair_step_t r;
    logic       qualify;
    logic       press_seen;
    logic       enabled;
    ms_t        since_change;
    ms_t        since_press;
    ms_t        since_enable;
    since_change = now - s.sample_change_time;
    since_press  = now - s.press_time;
    since_enable = now - s.enable_time;
    r.st         = s;
    press_seen   = 1'b0;
    enabled      = 1'b0;
    r.st.request_latch = s.request_latch & permit;

    if (pressed != s.raw_pressed) begin
      r.st.raw_pressed        = pressed;
      r.st.sample_change_time = now;
    end

    qualify = (pressed == s.raw_pressed) && (s.raw_pressed != s.stable_pressed) &&
              (since_change >= c.settle_ms);

    // A qualified edge of the debounced level.
    if (qualify) begin
      r.st.stable_pressed = s.raw_pressed;
      if (!s.raw_pressed) begin
        r.st.armed      = 1'b1;
        r.st.stuck_flag = 1'b0;
        if (c.maintained) begin
          r.st.request_latch = 1'b0;
        end
      end else begin
        press_seen      = 1'b1;
        r.st.press_time = now;
        if (s.armed) begin
          if (!c.maintained) begin
            r.st.armed         = 1'b0;
            r.st.request_latch = permit & ~r.st.request_latch;
          end else begin
            r.st.request_latch = permit;
          end
          if (r.st.request_latch) begin
            enabled          = 1'b1;
            r.st.enable_time = now;
          end
        end
      end
    end

    // A press held too long in toggle mode drops the request.
    if (!c.maintained && r.st.stable_pressed && !press_seen &&
        (since_press >= c.hold_limit_ms)) begin
      r.st.stuck_flag    = 1'b1;
      r.st.request_latch = 1'b0;
    end

    r.chan1 = r.st.request_latch & ~r.st.stuck_flag;
    r.chan2 = r.chan1 && !enabled && (since_enable >= c.chan2_delay_ms);
    return r;
  endfunction

  // State of a pair after a start item.
  function automatic pair_state_t pair_start(logic pressed, ms_t now);
    pair_state_t s;
    s.raw_pressed        = pressed;
    s.stable_pressed     = pressed;
    s.armed              = ~pressed;
    s.request_latch      = 1'b0;
    s.stuck_flag         = 1'b0;
    s.sample_change_time = now;
    s.press_time         = now;
    s.enable_time        = now;
    return s;
  endfunction

  function automatic logic pair_cfg_valid(pair_cfg_t c);
    return (c.settle_ms != '0) && (c.hold_limit_ms > c.settle_ms) &&
           (c.chan2_delay_ms != '0);
  endfunction

  pair_cfg_t   cfg_a;
  pair_cfg_t   cfg_b;
  logic        cfg_ok;
  logic        hold_valid;
  sample_t     hold;
  logic        started;
  logic        started_next;
  pair_state_t pair_a;
  pair_state_t pair_a_next;
  pair_state_t pair_b;
  pair_state_t pair_b_next;
  result_t     result_next;
  logic        slot_free;
  logic        advance;
  logic        permit;
  pair_step_t  step_a;
  pair_step_t  step_b;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_a <= '{settle_ms: DebounceReset, hold_limit_ms: StuckReset,
                 chan2_delay_ms: DelayReset, maintained: 1'b0};
      cfg_b <= '{settle_ms: DebounceReset, hold_limit_ms: StuckReset,
                 chan2_delay_ms: DelayReset, maintained: 1'b0};
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_A_DEBOUNCE: cfg_a.settle_ms      <= cfg_data;
        CFG_A_STUCK:    cfg_a.hold_limit_ms  <= cfg_data;
        CFG_A_DELAY:    cfg_a.chan2_delay_ms <= cfg_data;
        CFG_A_MODE:     cfg_a.maintained     <= cfg_data[0];
        CFG_B_DEBOUNCE: cfg_b.settle_ms      <= cfg_data;
        CFG_B_STUCK:    cfg_b.hold_limit_ms  <= cfg_data;
        CFG_B_DELAY:    cfg_b.chan2_delay_ms <= cfg_data;
        CFG_B_MODE:     cfg_b.maintained     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Validity follows the current register contents.
  assign cfg_ok = pair_cfg_valid(cfg_a) && pair_cfg_valid(cfg_b);

  // Handshake between the input register and the result register.
  assign slot_free    = !result_valid || result_ready;
  assign advance      = hold_valid && slot_free;
  assign sample_ready = !hold_valid || slot_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (sample_valid && sample_ready) begin
      hold_valid <= 1'b1;
    end else if (advance) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_valid && sample_ready) begin
      hold <= sample;
    end
  end

  // One processing pass over the held sample.
  assign permit = hold.setup_ok & hold.no_fault & hold.voltage_ok &
                  hold.current_ok & hold.thermal_ok;
  assign step_a = pair_step(pair_a, ~hold.a_level, hold.now_ms, permit, cfg_a);
  assign step_b = pair_step(pair_b, ~hold.b_level, hold.now_ms, permit, cfg_b);

  always_comb begin
    started_next = started;
    pair_a_next  = pair_a;
    pair_b_next  = pair_b;
    result_next  = '0;
    if (cfg_ok) begin
      if (hold.action == ActStart) begin
        started_next = 1'b1;
        pair_a_next  = pair_start(~hold.a_level, hold.now_ms);
        pair_b_next  = pair_start(~hold.b_level, hold.now_ms);
      end else if (started) begin
        pair_a_next           = step_a.st;
        pair_b_next           = step_b.st;
        result_next.a_request = step_a.st.request_latch;
        result_next.b_request = step_b.st.request_latch;
        result_next.a_chan1   = step_a.chan1;
        result_next.a_chan2   = step_a.chan2;
        result_next.b_chan1   = step_b.chan1;
        result_next.b_chan2   = step_b.chan2;
        result_next.a_stuck   = step_a.st.stuck_flag;
        result_next.b_stuck   = step_b.st.stuck_flag;
      end
    end
  end

  // Pair state advances with each sample that moves into the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      started <= 1'b0;
      pair_a  <= '0;
      pair_b  <= '0;
    end else if (advance) begin
      started <= started_next;
      pair_a  <= pair_a_next;
      pair_b  <= pair_b_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= result_next;
    end
  end

  `ASSERT_CLK(a_empty_slot_ready, !result_valid |-> sample_ready,
              "sample_ready low with an empty result register")
  `ASSERT_CLK(a_advance_gives_result, advance |=> result_valid,
              "processed sample did not reach the result register")
  `ASSERT_CLK(a_invalid_cfg_freezes, (advance && !cfg_ok) |=>
              ($stable(started) && $stable(pair_a) && $stable(pair_b)),
              "pair state changed under an invalid configuration")
  `ASSERT_CLK_ALWAYS(a_chan_consistent, result_valid |->
              (!(result.a_chan2 && !result.a_chan1) && !(result.b_chan2 && !result.b_chan1) &&
               !(result.a_chan1 && (result.a_stuck || !result.a_request)) &&
               !(result.b_chan1 && (result.b_stuck || !result.b_request))),
              "channel drive disagrees with request or stuck flag")

endmodule

`default_nettype wire

FILE: tb/sv/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dsrq_pkg::*;

  localparam logic [4:0] PermitAll = 5'h1f;

  // Receiver stall patterns.
  typedef enum logic [1:0] {
    RDY_ALWAYS,
    RDY_RANDOM,
    RDY_SPARSE,
    RDY_BURSTY
  } stall_mode_t;

  logic clk;
  logic rst = 1'b1;
  logic sample_valid = 1'b0;
  logic sample_ready;
  sample_t sample = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  result_t result;
  logic cfg_write = 1'b0;
  logic [CfgIndexWidth-1:0] cfg_index = '0;
  logic [CfgDataWidth-1:0] cfg_data = '0;

  dual_switch_request_qualifier u_top (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // Samples waiting to be driven and results predicted but not yet seen.
  sample_t queued_samples[$];
  result_t due_results[$];
  int unsigned mismatch_count = 0;
  int unsigned results_seen = 0;

  // Shadow copy of the settings and of the pair state (index 0 is pair A).
  pair_cfg_t pair_set[2];
  pair_state_t pair_st[2];
  logic run_started;

  // Stimulus generator state.
  ms_t clock_ms;
  logic gen_level[2];
  int unsigned gen_hold[2];

  // Sender and receiver pacing.
  logic in_taken = 1'b0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  stall_mode_t stall_mode = RDY_ALWAYS;
  int unsigned pat_left = 0;
  int unsigned pat_phase = 0;
  result_t head_result;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  task automatic flag_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= 100) begin
      $display("MISMATCH at %0t, result %0d: %s", $time, results_seen, msg);
    end
  endtask

  task automatic check_field(string name, logic got, logic want);
    if (got !== want) begin
      flag_mismatch($sformatf("%s got %b want %b", name, got, want));
    end
  endtask

  function automatic logic config_usable();
    for (int p = 0; p < 2; p++) begin
      if (pair_set[p].settle_ms == '0 ||
          pair_set[p].hold_limit_ms <= pair_set[p].settle_ms ||
          pair_set[p].chan2_delay_ms == '0) begin
        return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  // One debounce and latch step of a single pair; all time differences wrap.
  function automatic pair_state_t advance_pair(pair_state_t st, logic pressed, ms_t now,
                                               logic permit, pair_cfg_t c);
    pair_state_t n;
    n = st;
    if (!permit) begin
      n.request_latch = 1'b0;
    end
    if (pressed != n.raw_pressed) begin
      n.raw_pressed = pressed;
      n.sample_change_time = now;
    end
    if (n.raw_pressed != n.stable_pressed &&
        ms_t'(now - n.sample_change_time) >= c.settle_ms) begin
      n.stable_pressed = n.raw_pressed;
      if (!n.stable_pressed) begin
        n.armed = 1'b1;
        n.stuck_flag = 1'b0;
        if (c.maintained) begin
          n.request_latch = 1'b0;
        end
      end else begin
        n.press_time = now;
        if (n.armed) begin
          if (!c.maintained) begin
            n.armed = 1'b0;
            n.request_latch = permit ? !n.request_latch : 1'b0;
          end else begin
            n.request_latch = permit;
          end
          if (n.request_latch) begin
            n.enable_time = now;
          end
        end
      end
    end
    if (!c.maintained && n.stable_pressed &&
        ms_t'(now - n.press_time) >= c.hold_limit_ms) begin
      n.stuck_flag = 1'b1;
      n.request_latch = 1'b0;
    end
    return n;
  endfunction

  // Predicts the result of one transferred sample and advances the shadow state.
  function automatic result_t qualify_sample(sample_t s);
    result_t r;
    logic permit;
    logic pressed[2];
    logic on[2];
    logic late[2];
    r = '0;
    permit = s.setup_ok & s.no_fault & s.voltage_ok & s.current_ok & s.thermal_ok;
    pressed[0] = !s.a_level;
    pressed[1] = !s.b_level;
    if (!config_usable()) begin
      return r;
    end
    if (s.action == ActStart) begin
      for (int p = 0; p < 2; p++) begin
        pair_st[p].raw_pressed = pressed[p];
        pair_st[p].stable_pressed = pressed[p];
        pair_st[p].armed = !pressed[p];
        pair_st[p].request_latch = 1'b0;
        pair_st[p].stuck_flag = 1'b0;
        pair_st[p].sample_change_time = s.now_ms;
        pair_st[p].press_time = s.now_ms;
        pair_st[p].enable_time = s.now_ms;
      end
      run_started = 1'b1;
      return r;
    end
    if (!run_started) begin
      return r;
    end
    for (int p = 0; p < 2; p++) begin
      pair_st[p] = advance_pair(pair_st[p], pressed[p], s.now_ms, permit, pair_set[p]);
      on[p] = pair_st[p].request_latch && !pair_st[p].stuck_flag;
      late[p] = ms_t'(s.now_ms - pair_st[p].enable_time) >= pair_set[p].chan2_delay_ms;
    end
    r.a_request = pair_st[0].request_latch;
    r.b_request = pair_st[1].request_latch;
    r.a_chan1 = on[0];
    r.a_chan2 = on[0] && late[0];
    r.b_chan1 = on[1];
    r.b_chan2 = on[1] && late[1];
    r.a_stuck = pair_st[0].stuck_flag;
    r.b_stuck = pair_st[1].stuck_flag;
    return r;
  endfunction

  task automatic write_reg(cfg_reg_t idx, logic [CfgDataWidth-1:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
    case (idx)
      CFG_A_DEBOUNCE: pair_set[0].settle_ms = val;
      CFG_A_STUCK:    pair_set[0].hold_limit_ms = val;
      CFG_A_DELAY:    pair_set[0].chan2_delay_ms = val;
      CFG_A_MODE:     pair_set[0].maintained = val[0];
      CFG_B_DEBOUNCE: pair_set[1].settle_ms = val;
      CFG_B_STUCK:    pair_set[1].hold_limit_ms = val;
      CFG_B_DELAY:    pair_set[1].chan2_delay_ms = val;
      CFG_B_MODE:     pair_set[1].maintained = val[0];
      default: ;
    endcase
  endtask

  // Writes all four registers of one pair; the mode word carries random upper bits.
  task automatic set_pair(int p, ms_t deb, ms_t stuck, ms_t delay, logic maint);
    logic [CfgDataWidth-1:0] mode_word;
    mode_word = $urandom();
    mode_word[0] = maint;
    if (p == 0) begin
      write_reg(CFG_A_DEBOUNCE, deb);
      write_reg(CFG_A_STUCK, stuck);
      write_reg(CFG_A_DELAY, delay);
      write_reg(CFG_A_MODE, mode_word);
    end else begin
      write_reg(CFG_B_DEBOUNCE, deb);
      write_reg(CFG_B_STUCK, stuck);
      write_reg(CFG_B_DELAY, delay);
      write_reg(CFG_B_MODE, mode_word);
    end
  endtask

  task automatic push_item(logic act, logic a_lvl, logic b_lvl, ms_t now, logic [4:0] perm);
    sample_t s;
    s.action = act;
    s.a_level = a_lvl;
    s.b_level = b_lvl;
    s.now_ms = now;
    {s.setup_ok, s.no_fault, s.voltage_ok, s.current_ok, s.thermal_ok} = perm;
    queued_samples.push_back(s);
  endtask

  // An optional start followed by updates with held levels, mostly full permit, and some noise.
  task automatic run_session(int n, int unsigned step_max, int unsigned long_hold,
                             logic with_start);
    logic [4:0] perm;
    if (with_start) begin
      push_item(ActStart, gen_level[0], gen_level[1], clock_ms, PermitAll);
    end
    repeat (n) begin
      if ($urandom_range(0, 39) == 0) begin
        push_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), $urandom(), 5'($urandom_range(0, 31)));
      end else begin
        for (int p = 0; p < 2; p++) begin
          if (gen_hold[p] == 0) begin
            gen_level[p] = !gen_level[p];
            gen_hold[p] = ($urandom_range(0, 7) == 0) ? $urandom_range(1, long_hold)
                                                       : $urandom_range(1, 6);
          end
          gen_hold[p]--;
        end
        clock_ms += ms_t'($urandom_range(0, step_max));
        perm = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31)) : PermitAll;
        push_item(ActUpdate, gen_level[0], gen_level[1], clock_ms, perm);
      end
    end
  endtask

  // Waits until every queued sample has been transferred and every result has arrived.
  task automatic settle(int unsigned extra);
    do begin
      @(posedge clk);
    end while (queued_samples.size() != 0 || sample_valid || due_results.size() != 0);
    repeat (extra) @(posedge clk);
  endtask

  // Sender: bursts of random length separated by random gaps.
  always @(negedge clk) begin
    if (!rst && !(sample_valid && !in_taken)) begin
      in_taken = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        sample_valid <= 1'b0;
      end else if (queued_samples.size() > 0) begin
        sample <= queued_samples.pop_front();
        sample_valid <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        sample_valid <= 1'b0;
      end
    end
  end

  // Receiver: switches among stall patterns after a run of random length.
  always @(negedge clk) begin
    if (pat_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      pat_left = $urandom_range(30, 200);
    end
    pat_left--;
    pat_phase++;
    case (stall_mode)
      RDY_ALWAYS: result_ready <= 1'b1;
      RDY_RANDOM: result_ready <= 1'($urandom_range(0, 1));
      RDY_SPARSE: result_ready <= (pat_phase % 4 == 0);
      default:    result_ready <= (pat_phase % 16 >= 10);
    endcase
  end

  // Monitor: predicts on each input transfer and checks each result transfer.
  always @(posedge clk) begin
    if (!rst) begin
      if (sample_valid && sample_ready) begin
        due_results.push_back(qualify_sample(sample));
        in_taken = 1'b1;
      end
      if (result_valid && result_ready) begin
        results_seen++;
        if (due_results.size() == 0) begin
          flag_mismatch("result transfer with nothing expected");
        end else begin
          head_result = due_results.pop_front();
          check_field("a_request", result.a_request, head_result.a_request);
          check_field("b_request", result.b_request, head_result.b_request);
          check_field("a_chan1", result.a_chan1, head_result.a_chan1);
          check_field("a_chan2", result.a_chan2, head_result.a_chan2);
          check_field("b_chan1", result.b_chan1, head_result.b_chan1);
          check_field("b_chan2", result.b_chan2, head_result.b_chan2);
          check_field("a_stuck", result.a_stuck, head_result.a_stuck);
          check_field("b_stuck", result.b_stuck, head_result.b_stuck);
        end
      end
    end
  end

  initial begin
    for (int p = 0; p < 2; p++) begin
      pair_set[p].settle_ms = DebounceReset;
      pair_set[p].hold_limit_ms = StuckReset;
      pair_set[p].chan2_delay_ms = DelayReset;
      pair_set[p].maintained = 1'b0;
      pair_st[p] = '0;
      gen_level[p] = 1'b1;
      gen_hold[p] = 0;
    end
    run_started = 1'b0;
    clock_ms = 32'd1000;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // An update before any start gives an all-zero result.
    push_item(ActUpdate, 1'b0, 1'b0, 32'd0, PermitAll);
    settle(4);

    // Pair A toggles, pair B follows the held switch.
    set_pair(0, 32'd3, 32'd40, 32'd10, 1'b0);
    set_pair(1, 32'd5, 32'd25, 32'd7, 1'b1);
    push_item(ActStart, 1'b0, 1'b1, 32'd100, PermitAll);
    push_item(ActUpdate, 1'b1, 1'b0, 32'd101, PermitAll);
    push_item(ActUpdate, 1'b1, 1'b0, 32'd103, PermitAll);
    push_item(ActUpdate, 1'b1, 1'b0, 32'd106, PermitAll);
    push_item(ActUpdate, 1'b1, 1'b0, 32'd113, PermitAll);
    push_item(ActUpdate, 1'b0, 1'b0, 32'd114, PermitAll);
    push_item(ActUpdate, 1'b0, 1'b0, 32'd117, PermitAll);
    push_item(ActUpdate, 1'b0, 1'b0, 32'd127, PermitAll);
    // Each permit term dropped on its own.
    for (int i = 0; i < 5; i++) begin
      push_item(ActUpdate, 1'b0, 1'b0, 32'd128 + i, PermitAll ^ (5'b1 << i));
    end
    // Press held past the stuck timeout, then released.
    push_item(ActUpdate, 1'b0, 1'b0, 32'd157, PermitAll);
    push_item(ActUpdate, 1'b1, 1'b1, 32'd160, PermitAll);
    push_item(ActUpdate, 1'b1, 1'b1, 32'd170, PermitAll);
    // Debounce and channel delay across the wrap of the clock.
    push_item(ActStart, 1'b1, 1'b1, 32'hFFFF_FFFE, PermitAll);
    push_item(ActUpdate, 1'b0, 1'b0, 32'hFFFF_FFFF, PermitAll);
    push_item(ActUpdate, 1'b0, 1'b0, 32'h0000_0000, PermitAll);
    push_item(ActUpdate, 1'b0, 1'b0, 32'h0000_0004, PermitAll);
    push_item(ActUpdate, 1'b0, 1'b0, 32'h0000_000E, PermitAll);
    // Release, then a press that qualifies while the permit is off.
    push_item(ActUpdate, 1'b1, 1'b1, 32'd20, PermitAll);
    push_item(ActUpdate, 1'b1, 1'b1, 32'd30, PermitAll);
    push_item(ActUpdate, 1'b0, 1'b0, 32'd31, 5'h00);
    push_item(ActUpdate, 1'b0, 1'b0, 32'd40, 5'h00);
    run_session(300, 6, 30, 1'b1);
    settle(4);

    // Default-like timing on pair A, small values on B.
    set_pair(0, DebounceReset, StuckReset, DelayReset, 1'b0);
    set_pair(1, 32'd2, 32'd12, 32'd5, 1'b0);
    run_session(150, 120, 30, 1'b1);
    settle(4);

    // Modes swapped.
    set_pair(0, 32'd4, 32'd30, 32'd6, 1'b1);
    set_pair(1, 32'd3, 32'd20, 32'd9, 1'b0);
    run_session(250, 7, 25, 1'b1);
    settle(4);

    // Extremes: the smallest valid settings on A, the largest on B.
    set_pair(0, 32'd1, 32'd2, 32'd1, 1'b0);
    set_pair(1, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    clock_ms = 32'hFFFF_FF00;
    run_session(110, 3, 10, 1'b1);
    push_item(ActUpdate, 1'b1, 1'b0, clock_ms + 32'd1, PermitAll);
    push_item(ActUpdate, 1'b1, 1'b0, clock_ms + 32'hFFFF_FFFF, PermitAll);
    push_item(ActUpdate, 1'b1, 1'b0, clock_ms, PermitAll);
    run_session(40, 32'hFFFF_FFFF, 6, 1'b0);
    settle(4);

    set_pair(0, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    set_pair(1, 32'd1, 32'd2, 32'd1, 1'b1);
    run_session(40, 32'hFFFF_FFFF, 6, 1'b1);
    settle(4);

    // Invalid settings freeze the state; restoring them resumes without a start.
    set_pair(0, 32'd3, 32'd30, 32'd8, 1'b0);
    set_pair(1, 32'd2, 32'd15, 32'd4, 1'b1);
    run_session(30, 5, 20, 1'b1);
    settle(4);
    write_reg(CFG_B_DELAY, 32'd0);
    run_session(15, 5, 20, 1'b1);
    settle(4);
    write_reg(CFG_B_DELAY, 32'd4);
    run_session(15, 5, 20, 1'b0);
    settle(4);
    write_reg(CFG_A_DEBOUNCE, 32'd0);
    run_session(15, 5, 20, 1'b0);
    settle(4);
    write_reg(CFG_A_DEBOUNCE, 32'd30);
    run_session(15, 5, 20, 1'b1);
    settle(4);
    write_reg(CFG_A_DEBOUNCE, 32'd3);
    write_reg(CFG_B_STUCK, 32'd1);
    run_session(15, 5, 20, 1'b0);
    settle(4);
    write_reg(CFG_B_STUCK, 32'd15);
    run_session(20, 5, 20, 1'b0);
    settle(4);

    // Both pairs toggling with short timeouts.
    set_pair(0, 32'd2, 32'd15, 32'd4, 1'b0);
    set_pair(1, 32'd1, 32'd9, 32'd3, 1'b0);
    run_session(300, 4, 20, 1'b1);

    settle(20);
    if (due_results.size() != 0) begin
      flag_mismatch($sformatf("%0d expected results never arrived", due_results.size()));
    end
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
